// ===== sv/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation unit.
package mexp_pkg;

    // Width of the external operand and result ports.
    localparam int unsigned IO_W = 32;

    // Source of the multiplier shift register when a new multiplication starts.
    typedef enum logic [1:0] {
        SH_SEL_ACC  = 2'd0,
        SH_SEL_BASE = 2'd1,
        SH_SEL_STEP = 2'd2
    } t_sh_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;         // capture a new word from the input port
        logic    step;         // run one shift-add reduction step
        logic    step_reduce;  // step adds the next base bit instead of the multiplicand
        logic    clear_p;      // restart the partial product at zero
        logic    commit_base;  // step result becomes the base
        logic    commit_acc;   // step result becomes the running result
        logic    shift_expo;   // drop the exponent bit just handled
        logic    sh_load;      // reload the multiplier shift register
        t_sh_sel sh_sel;
        logic    out_load;     // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_zero_in;   // modulus at the input port is zero
        logic expo_zero_in;  // exponent at the input port is zero
        logic expo_b0;       // exponent bit being handled
        logic expo_b1;       // exponent bit handled next
        logic expo_hi_zero;  // no one bits above the current exponent bit
        logic out_busy;      // output register full and not taken this cycle
    } t_status;

endpackage

// ===== sv/mexp_ctrl.sv =====
// Sequencing controller for the modular exponentiation unit.
module mexp_ctrl
    import mexp_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int unsigned CNT_W = $clog2(WIDTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_MUL  = 5'b00100,
        S_SQR  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             last_step;

    assign last_step  = (r_cnt == CNT_W'(WIDTH - 1));
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.mod_zero_in || i_status.expo_zero_in) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                o_cmd.step        = 1'b1;
                o_cmd.step_reduce = 1'b1;
                n_cnt             = r_cnt + 1'b1;
                if (last_step) begin
                    n_cnt             = '0;
                    o_cmd.clear_p     = 1'b1;
                    o_cmd.commit_base = 1'b1;
                    o_cmd.sh_load     = 1'b1;
                    if (i_status.expo_b0) begin
                        o_cmd.sh_sel = SH_SEL_ACC;
                        n_state      = S_MUL;
                    end else begin
                        o_cmd.sh_sel = SH_SEL_STEP;
                        n_state      = S_SQR;
                    end
                end
            end
            S_MUL: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (last_step) begin
                    n_cnt            = '0;
                    o_cmd.clear_p    = 1'b1;
                    o_cmd.commit_acc = 1'b1;
                    if (i_status.expo_hi_zero) begin
                        n_state = S_OUT;
                    end else begin
                        o_cmd.sh_load = 1'b1;
                        o_cmd.sh_sel  = SH_SEL_BASE;
                        n_state       = S_SQR;
                    end
                end
            end
            S_SQR: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (last_step) begin
                    n_cnt             = '0;
                    o_cmd.clear_p     = 1'b1;
                    o_cmd.commit_base = 1'b1;
                    o_cmd.shift_expo  = 1'b1;
                    o_cmd.sh_load     = 1'b1;
                    if (i_status.expo_b1) begin
                        o_cmd.sh_sel = SH_SEL_ACC;
                        n_state      = S_MUL;
                    end else begin
                        o_cmd.sh_sel = SH_SEL_STEP;
                        n_state      = S_SQR;
                    end
                end
            end
            S_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== sv/mexp_dp.sv =====
// Operand registers, shift-add modular reducer and output register.
module mexp_dp
    import mexp_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    output t_status         o_status,
    input  logic [IO_W-1:0] i_base_value,
    input  logic [IO_W-1:0] i_exponent_value,
    input  logic [IO_W-1:0] i_modulus_value,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [IO_W-1:0] o_power_result,
    output logic            o_zero_modulus_error
);

    logic [WIDTH-1:0] base_w, expo_w, mod_w;
    logic [WIDTH-1:0] r_mod, r_base, r_acc, r_expo, r_p, r_sh;
    logic             r_err;
    logic             r_out_valid;
    logic [IO_W-1:0]  r_out_res;
    logic             r_out_err;
    logic [IO_W-1:0]  acc_io;
    logic [WIDTH-1:0] addend, step_out, sh_next, acc_init;
    logic [WIDTH+1:0] t_sum, d_one, d_two, mod_x1, mod_x2;
    logic             mod_zero_in, mod_one_in, expo_zero_in;

    // Operands are taken at the working width; results leave at port width.
    if (WIDTH > IO_W) begin : g_wide
        assign base_w = {{(WIDTH - IO_W){1'b0}}, i_base_value};
        assign expo_w = {{(WIDTH - IO_W){1'b0}}, i_exponent_value};
        assign mod_w  = {{(WIDTH - IO_W){1'b0}}, i_modulus_value};
        assign acc_io = r_acc[IO_W-1:0];
    end else if (WIDTH == IO_W) begin : g_same
        assign base_w = i_base_value;
        assign expo_w = i_exponent_value;
        assign mod_w  = i_modulus_value;
        assign acc_io = r_acc;
    end else begin : g_narrow
        assign base_w = i_base_value[WIDTH-1:0];
        assign expo_w = i_exponent_value[WIDTH-1:0];
        assign mod_w  = i_modulus_value[WIDTH-1:0];
        assign acc_io = {{(IO_W - WIDTH){1'b0}}, r_acc};
    end

    assign mod_zero_in  = (mod_w == '0);
    assign mod_one_in   = (mod_w == WIDTH'(1));
    assign expo_zero_in = (expo_w == '0);

    // A unit modulus sends any nonzero power to zero; a zero exponent gives one.
    assign acc_init = (mod_zero_in || (mod_one_in && !expo_zero_in)) ? '0 : WIDTH'(1);

    // One reducer step: p = 2p + addend, brought back below the modulus.
    // With p and addend below m the sum stays below 3m.
    assign addend = i_cmd.step_reduce ? WIDTH'(r_sh[WIDTH-1]) :
                    (r_sh[WIDTH-1] ? r_base : '0);
    assign mod_x1 = {2'b00, r_mod};
    assign mod_x2 = {1'b0, r_mod, 1'b0};
    assign t_sum  = {1'b0, r_p, 1'b0} + {2'b00, addend};
    assign d_one  = t_sum - mod_x1;
    assign d_two  = t_sum - mod_x2;

    always_comb begin
        if (t_sum >= mod_x2) begin
            step_out = d_two[WIDTH-1:0];
        end else if (t_sum >= mod_x1) begin
            step_out = d_one[WIDTH-1:0];
        end else begin
            step_out = t_sum[WIDTH-1:0];
        end
    end

    always_comb begin
        case (i_cmd.sh_sel)
            SH_SEL_ACC:  sh_next = r_acc;
            SH_SEL_BASE: sh_next = r_base;
            SH_SEL_STEP: sh_next = step_out;
            default:     sh_next = step_out;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mod  <= mod_w;
            r_expo <= expo_w;
            r_sh   <= base_w;
            r_p    <= '0;
            r_acc  <= acc_init;
            r_err  <= mod_zero_in;
        end else begin
            if (i_cmd.step) begin
                r_p <= i_cmd.clear_p ? '0 : step_out;
            end
            if (i_cmd.sh_load) begin
                r_sh <= sh_next;
            end else if (i_cmd.step) begin
                r_sh <= {r_sh[WIDTH-2:0], 1'b0};
            end
            if (i_cmd.commit_base) begin
                r_base <= step_out;
            end
            if (i_cmd.commit_acc) begin
                r_acc <= step_out;
            end
            if (i_cmd.shift_expo) begin
                r_expo <= {1'b0, r_expo[WIDTH-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_res <= acc_io;
            r_out_err <= r_err;
        end
    end

    assign o_status.mod_zero_in  = mod_zero_in;
    assign o_status.expo_zero_in = expo_zero_in;
    assign o_status.expo_b0      = r_expo[0];
    assign o_status.expo_b1      = r_expo[1];
    assign o_status.expo_hi_zero = (r_expo[WIDTH-1:1] == '0);
    assign o_status.out_busy     = r_out_valid && i_out_stall;

    assign o_out_valid          = r_out_valid;
    assign o_power_result       = r_out_res;
    assign o_zero_modulus_error = r_out_err;

endmodule

// ===== sv/modular_exponentiation_unit.sv =====
// Top level of the modular exponentiation unit: controller, datapath and checks.
//
// Each input word carries a base, an exponent and a modulus; the unit returns one
// output word with base to the exponent modulo the modulus, computed right to left
// by square-and-multiply at WIDTH bits (operands are cut or zero-extended to WIDTH,
// the result is presented on 32 bits). A zero modulus returns 0 with
// o_zero_modulus_error set, and a zero exponent returns 1 even for a modulus of one.
// All modular products go through one shared shift-add reducer that handles one
// multiplier bit per cycle; the same reducer first brings the base below the
// modulus. A zero modulus or zero exponent skips the reducer and goes straight to
// the output register. The unit works on one word at a time and holds o_in_stall
// high while busy. The finished result sits in an output register, so a new word
// is taken while an earlier result still waits downstream.
module modular_exponentiation_unit
    import mexp_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [IO_W-1:0] i_base_value,
    input  logic [IO_W-1:0] i_exponent_value,
    input  logic [IO_W-1:0] i_modulus_value,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [IO_W-1:0] o_power_result,
    output logic            o_zero_modulus_error
);

    t_cmd    cmd;
    t_status status;

    // The controller steps through base reduction, multiplies and squares.
    mexp_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the operands, the reducer and the output register.
    mexp_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_base_value         (i_base_value),
        .i_exponent_value     (i_exponent_value),
        .i_modulus_value      (i_modulus_value),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_power_result       (o_power_result),
        .o_zero_modulus_error (o_zero_modulus_error)
    );

    // Once a word is taken, the unit is busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("unit not busy after taking a word");

    // An error result always carries a zero value.
    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_modulus_error) |-> (o_power_result == '0))
        else $error("zero modulus error with nonzero result");

    // A new result appears only at the end of a busy period.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load) |-> o_in_stall)
        else $error("result loaded while the unit was idle");

endmodule

// ===== tb/sv/modular_exponentiation_unit_tb.sv =====
// Self-checking testbench for the modular exponentiation unit.
module modular_exponentiation_unit_tb
    import mexp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The run is split into three stretches by the number of input words taken.
    // In the first the sender idles rarely and the receiver often, in the second
    // the other way round, and in the last neither side idles.
    localparam int unsigned STRETCH_WORDS = 100;
    localparam int unsigned RANDOM_WORDS  = 272;

    // The drain covers one word at its slowest, and the limit covers every word at its
    // slowest several times over.
    localparam int unsigned DRAIN_CYCLES = 2200;
    localparam longint unsigned CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [IO_W-1:0] base_value;
        logic [IO_W-1:0] exponent_value;
        logic [IO_W-1:0] modulus_value;
    } t_operand_word;

    typedef struct packed {
        logic [IO_W-1:0] power_result;
        logic            zero_modulus_error;
    } t_power_word;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    logic [IO_W-1:0] in_base = '0;
    logic [IO_W-1:0] in_exponent = '0;
    logic [IO_W-1:0] in_modulus = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [IO_W-1:0] out_power;
    logic            out_zero_mod;

    t_operand_word   pending_operands[$];
    t_power_word     expected_powers[$];
    t_operand_word   next_operands;
    t_power_word     oldest_power;
    int unsigned     words_taken = 0;
    int unsigned     mismatches = 0;
    longint unsigned cycle_count = 0;

    modular_exponentiation_unit i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_base_value        (in_base),
        .i_exponent_value    (in_exponent),
        .i_modulus_value     (in_modulus),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_power_result      (out_power),
        .o_zero_modulus_error(out_zero_mod)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Expected result of one word: right-to-left square-and-multiply with the
    // products held at 64 bits, so that nothing wraps before the reduction.
    // A zero exponent leaves the running result at one, even for a modulus of one.
    function automatic t_power_word predict_power(t_operand_word w);
        t_power_word      r;
        logic [63:0]      m;
        logic [63:0]      square;
        logic [63:0]      acc;
        logic [IO_W-1:0]  e;
        r.zero_modulus_error = (w.modulus_value == '0);
        r.power_result = '0;
        if (!r.zero_modulus_error) begin
            m = {32'd0, w.modulus_value};
            square = {32'd0, w.base_value} % m;
            acc = 64'd1;
            e = w.exponent_value;
            while (e != '0) begin
                if (e[0]) begin
                    acc = ((acc % m) * square) % m;
                end
                square = (square * square) % m;
                e = e >> 1;
            end
            r.power_result = acc[IO_W-1:0];
        end
        return r;
    endfunction

    // Idle chance in percent for one side, taken from the current stretch.
    function automatic int unsigned idle_percent(bit sender);
        if (words_taken < STRETCH_WORDS) begin
            return sender ? 11 : 80;
        end else if (words_taken < 2 * STRETCH_WORDS) begin
            return sender ? 80 : 11;
        end
        return 0;
    endfunction

    // Random word with its fields drawn from a few classes, so that tiny and
    // full-width moduli, zero and all-ones operands and short exponents all occur.
    function automatic t_operand_word random_operands();
        t_operand_word w;
        int unsigned   k;
        k = $urandom_range(0, 19);
        case (k)
            0: begin
                w.modulus_value = '0;
            end
            1: begin
                w.modulus_value = 32'd1;
            end
            2, 3, 4: begin
                w.modulus_value = $urandom_range(2, 15);
            end
            5: begin
                w.modulus_value = 32'd1 << $urandom_range(1, 31);
            end
            6, 7, 8: begin
                w.modulus_value = $urandom | 32'h8000_0000;
            end
            9: begin
                w.modulus_value = 32'hFFFF_FFFF;
            end
            default: begin
                w.modulus_value = $urandom;
            end
        endcase
        k = $urandom_range(0, 19);
        case (k)
            0: begin
                w.base_value = '0;
            end
            1: begin
                w.base_value = 32'hFFFF_FFFF;
            end
            2, 3: begin
                w.base_value = $urandom_range(0, 20);
            end
            default: begin
                w.base_value = $urandom;
            end
        endcase
        k = $urandom_range(0, 19);
        case (k)
            0: begin
                w.exponent_value = '0;
            end
            1: begin
                w.exponent_value = 32'hFFFF_FFFF;
            end
            2, 3, 4, 5, 6, 7, 8: begin
                w.exponent_value = $urandom_range(1, 255);
            end
            9: begin
                w.exponent_value = 32'd1 << $urandom_range(0, 31);
            end
            default: begin
                w.exponent_value = $urandom;
            end
        endcase
        return w;
    endfunction

    task automatic report_mismatch(string field, logic [IO_W-1:0] got,
                                   logic [IO_W-1:0] want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, field,
                 got, want);
    endtask

    // Driver. A new word is presented only once the previous one has been taken,
    // and the payload holds still while the unit stalls. Each taken word gets its
    // expected result queued at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) begin
                expected_powers.push_back(predict_power({in_base, in_exponent,
                                                         in_modulus}));
                words_taken <= words_taken + 1;
            end
            if (pending_operands.size() != 0 &&
                $urandom_range(0, 99) >= idle_percent(1'b1)) begin
                next_operands = pending_operands.pop_front();
                in_base     <= next_operands.base_value;
                in_exponent <= next_operands.exponent_value;
                in_modulus  <= next_operands.modulus_value;
                in_valid    <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor. Every result word taken is checked field by field against the
    // oldest expectation; the stall toward the unit is redrawn every cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_powers.size() == 0) begin
                    report_mismatch("unexpected word, power_result", out_power, '0);
                end else begin
                    oldest_power = expected_powers.pop_front();
                    if (out_power !== oldest_power.power_result) begin
                        report_mismatch("power_result", out_power,
                                        oldest_power.power_result);
                    end
                    if (out_zero_mod !== oldest_power.zero_modulus_error) begin
                        report_mismatch("zero_modulus_error", IO_W'(out_zero_mod),
                                        IO_W'(oldest_power.zero_modulus_error));
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < idle_percent(1'b0));
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** modular_exponentiation_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        // Directed words: a zero modulus with any other fields, a zero exponent
        // against the smallest and largest moduli, a modulus of one, a zero base,
        // all-ones operands, a base above and below the modulus and single
        // exponent bits at both ends.
        pending_operands.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0});
        pending_operands.push_back('{32'd0, 32'd0, 32'd0});
        pending_operands.push_back('{32'd7, 32'd0, 32'd0});
        pending_operands.push_back('{32'd5, 32'd0, 32'd1});
        pending_operands.push_back('{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF});
        pending_operands.push_back('{32'd0, 32'd0, 32'd13});
        pending_operands.push_back('{32'd9, 32'd3, 32'd1});
        pending_operands.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1});
        pending_operands.push_back('{32'd0, 32'd5, 32'd97});
        pending_operands.push_back('{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        pending_operands.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        pending_operands.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB});
        pending_operands.push_back('{32'd2, 32'd31, 32'hFFFF_FFFF});
        pending_operands.push_back('{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF});
        pending_operands.push_back('{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE});
        pending_operands.push_back('{32'd3, 32'h8000_0000, 32'd1_000_000_007});
        pending_operands.push_back('{32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'd2});
        pending_operands.push_back('{32'd5, 32'd1, 32'd7});
        pending_operands.push_back('{32'd123_456_789, 32'd65_537, 32'h8000_0000});
        pending_operands.push_back('{32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAB});
        repeat (RANDOM_WORDS) begin
            pending_operands.push_back(random_operands());
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every word has been taken and every result has come back,
        // then give the unit time to show any stray result.
        while (pending_operands.size() != 0 || in_valid) begin
            @(posedge i_clk);
        end
        while (expected_powers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("** modular_exponentiation_unit: PASSED **");
        end else begin
            $display("** modular_exponentiation_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/mexp_pkg.sv
sv/mexp_ctrl.sv
sv/mexp_dp.sv
sv/modular_exponentiation_unit.sv
tb/sv/modular_exponentiation_unit_tb.sv
